>>> rtl/core/i64dec_pkg.sv
package i64dec_pkg;

    // Fixed field widths of the channels
    localparam int VALUE_W = 64;
    localparam int CHAR_W  = 6;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;

    localparam logic [3:0] BCD_FIVE  = 4'd5;
    localparam logic [3:0] BCD_THREE = 4'd3;
    localparam logic [3:0] BCD_NINE  = 4'd9;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_EMIT
    } state_t;

endpackage

>>> rtl/core/i64dec_num_if.sv
interface i64dec_num_if;
    logic                            valid;
    logic                            ready;
    logic [i64dec_pkg::VALUE_W-1:0]  value;
    logic                            command;

    modport source (output valid, output value, output command, input ready);
    modport sink   (input valid, input value, input command, output ready);
endinterface

>>> rtl/core/i64dec_text_if.sv
interface i64dec_text_if;
    logic                           valid;
    logic                           ready;
    logic [i64dec_pkg::CHAR_W-1:0]  character;
    logic                           last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

>>> rtl/core/int64_to_decimal_ascii.sv
// Channel  Dir  Payload                    Transaction
// num      in   value[63:0], command       one number to convert
// text     out  character[5:0], last       one ASCII character of the text
//
// One number passes an accept state, VALUE_BITS shift-add-3 steps in the shared
// BCD adjust/shift unit, a step that drops leading zeros, then a minus sign if
// negative and one character per digit.
// num.ready is high only while idle; text stalls hold the sequencer in place.
// rst_n clears the sequencer and the output valid asynchronously.
module int64_to_decimal_ascii #(
    parameter int VALUE_BITS = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    i64dec_num_if.sink           num,
    i64dec_text_if.source        text
);

    localparam int NDIG      = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int BCD_W     = 4 * NDIG;
    localparam int BIT_CNT_W = $clog2(VALUE_BITS + 1);
    localparam int DIG_CNT_W = $clog2(NDIG + 1);

    i64dec_pkg::state_t state_reg, state_next;

    logic [VALUE_BITS-1:0]              mag_reg, mag_next;
    logic [BCD_W-1:0]                   bcd_reg, bcd_next;
    logic [BCD_W-1:0]                   bcd_adj;
    logic                               neg_reg, neg_next;
    logic [BIT_CNT_W-1:0]               bit_cnt_reg, bit_cnt_next;
    logic [DIG_CNT_W-1:0]               dig_cnt_reg, dig_cnt_next;
    logic                               ovalid_reg, ovalid_next;
    logic [i64dec_pkg::CHAR_W-1:0]      char_reg, char_next;
    logic                               last_reg, last_next;

    logic [VALUE_BITS-1:0]              val_in;
    logic                               neg_in;
    logic                               out_free;
    logic                               load;
    logic [3:0]                         top_digit;
    logic                               bcd_ok;

    assign val_in    = num.value[VALUE_BITS-1:0];
    assign neg_in    = num.command & val_in[VALUE_BITS-1];
    assign out_free  = !ovalid_reg || text.ready;
    assign top_digit = bcd_reg[BCD_W-1 -: 4];

    assign num.ready      = (state_reg == i64dec_pkg::ST_IDLE);
    assign text.valid     = ovalid_reg;
    assign text.character = char_reg;
    assign text.last      = last_reg;

    // Shared unit: add 3 to every digit of five or more
    always_comb
    begin
        logic [3:0] d;
        for (int i = 0; i < NDIG; i++)
        begin
            d = bcd_reg[4*i +: 4];
            bcd_adj[4*i +: 4] = (d >= i64dec_pkg::BCD_FIVE) ? d + i64dec_pkg::BCD_THREE : d;
        end
    end

    always_comb
    begin
        bcd_ok = 1'b1;
        for (int i = 0; i < NDIG; i++)
        begin
            bcd_ok = bcd_ok && (bcd_reg[4*i +: 4] <= i64dec_pkg::BCD_NINE);
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        mag_next     = mag_reg;
        bcd_next     = bcd_reg;
        neg_next     = neg_reg;
        bit_cnt_next = bit_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        char_next    = char_reg;
        last_next    = last_reg;
        load         = 1'b0;

        unique case (state_reg)
            i64dec_pkg::ST_IDLE:
            begin
                if (num.valid)
                begin
                    mag_next     = neg_in ? VALUE_BITS'(~val_in + VALUE_BITS'(1)) : val_in;
                    neg_next     = neg_in;
                    bcd_next     = '0;
                    bit_cnt_next = BIT_CNT_W'(VALUE_BITS);
                    dig_cnt_next = DIG_CNT_W'(NDIG);
                    state_next   = i64dec_pkg::ST_CONV;
                end
            end
            i64dec_pkg::ST_CONV:
            begin
                bcd_next     = {bcd_adj[BCD_W-2:0], mag_reg[VALUE_BITS-1]};
                mag_next     = {mag_reg[VALUE_BITS-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - BIT_CNT_W'(1);
                if (bit_cnt_reg == BIT_CNT_W'(1))
                begin
                    state_next = i64dec_pkg::ST_SKIP;
                end
            end
            i64dec_pkg::ST_SKIP:
            begin
                // drop one leading zero per cycle, keep at least one digit
                if (top_digit == 4'd0 && dig_cnt_reg > DIG_CNT_W'(1))
                begin
                    bcd_next     = {bcd_reg[BCD_W-5:0], 4'd0};
                    dig_cnt_next = dig_cnt_reg - DIG_CNT_W'(1);
                end
                else
                begin
                    state_next = neg_reg ? i64dec_pkg::ST_SIGN : i64dec_pkg::ST_EMIT;
                end
            end
            i64dec_pkg::ST_SIGN:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    char_next  = i64dec_pkg::CHAR_MINUS;
                    last_next  = 1'b0;
                    state_next = i64dec_pkg::ST_EMIT;
                end
            end
            i64dec_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    load         = 1'b1;
                    char_next    = i64dec_pkg::CHAR_ZERO + {2'b00, top_digit};
                    last_next    = (dig_cnt_reg == DIG_CNT_W'(1));
                    bcd_next     = {bcd_reg[BCD_W-5:0], 4'd0};
                    dig_cnt_next = dig_cnt_reg - DIG_CNT_W'(1);
                    if (dig_cnt_reg == DIG_CNT_W'(1))
                    begin
                        state_next = i64dec_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = i64dec_pkg::ST_IDLE;
            end
        endcase

        ovalid_next = load ? 1'b1 : (text.ready ? 1'b0 : ovalid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= i64dec_pkg::ST_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg     <= mag_next;
        bcd_reg     <= bcd_next;
        neg_reg     <= neg_next;
        bit_cnt_reg <= bit_cnt_next;
        dig_cnt_reg <= dig_cnt_next;
        char_reg    <= char_next;
        last_reg    <= last_next;
    end

    a_accept_starts_conv: assert property (@(posedge clk) disable iff (!rst_n)
        num.valid && num.ready |=> state_reg == i64dec_pkg::ST_CONV)
        else $error("accepted number did not start conversion");

    a_bcd_digits_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == i64dec_pkg::ST_SKIP || state_reg == i64dec_pkg::ST_EMIT) |-> bcd_ok)
        else $error("BCD digit out of range after conversion");

    a_digit_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == i64dec_pkg::ST_SKIP || state_reg == i64dec_pkg::ST_EMIT)
        |-> dig_cnt_reg != DIG_CNT_W'(0))
        else $error("digit count ran out while emitting");

    a_last_not_minus: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg && last_reg |-> char_reg != i64dec_pkg::CHAR_MINUS)
        else $error("text ended on a minus sign");

    a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        load && last_next |=> state_reg == i64dec_pkg::ST_IDLE)
        else $error("sequencer not idle after final character");

endmodule
